>>> sv/calclk_pkg.sv
// calendar clock package: request codes, register indexes, month lengths
// and the gregorian leap-year rule
// no dependencies
package calclk_pkg;

  // field widths
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int H12_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = YEAR_W;

  // reset values
  localparam logic [YEAR_W-1:0]  YEAR_RESET     = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_MIN_RESET = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_MAX_RESET = 12'd2020;
  localparam logic [DAY_W-1:0]   DAY_RESET      = 5'd1;
  localparam logic [MONTH_W-1:0] MONTH_RESET    = 4'd1;

  // limits
  localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
  localparam logic [HOUR_W-1:0]  HOUR_NOON  = 5'd12;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [DAY_W-1:0]   DAY_LEAP   = 5'd29;
  localparam logic [H12_W-1:0]   H12_TWELVE = 4'd12;

  // request kinds
  typedef enum logic [0:0] {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YEAR_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_YEAR_MAX = 1'b1;

  // days per month, out-of-range month codes read as 31
  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // reciprocal of 25 for a 12-bit year: floor(y * 1311 / 2^15) == y / 25
  localparam int RECIP_25_W     = 11;
  localparam int RECIP_25_SHIFT = 15;
  localparam logic [RECIP_25_W-1:0] RECIP_25 = 11'd1311;
  localparam int PROD_W = YEAR_W + RECIP_25_W;
  localparam int QUOT_W = PROD_W - RECIP_25_SHIFT;

  // leap when divisible by 4 and either not by 100 or also by 400;
  // by 100 is by 4 and by 25, by 400 is by 16 and by 25
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [YEAR_W-1:0] back;
    logic              div25;
    prod  = PROD_W'(y) * PROD_W'(RECIP_25);
    quot  = prod[PROD_W-1:RECIP_25_SHIFT];
    // quot * 25 as shifts and adds
    back  = YEAR_W'({quot, 4'b0000}) + YEAR_W'({quot, 3'b000}) + YEAR_W'(quot);
    div25 = (back == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // length of a month, february stretched in leap years
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] mon,
                                               input logic               leap);
    logic [DAY_W-1:0] n;
    n = MONTH_LEN[mon];
    if (mon == MONTH_FEB && leap) n = DAY_LEAP;
    return n;
  endfunction

endpackage

>>> sv/calendar_clock_counter.sv
// calendar clock counter top level: time and date registers, tick carry,
// set checking and result register
// depends on calclk_pkg
//
// Real-time clock with a Gregorian calendar. Each request is either a
// one-second tick (req_type 0) or a set (req_type 1). A tick carries
// second into minute, hour, day, month and year, with month lengths and the
// leap rule of 4, 100 and 400; the year wraps from 4095 to 0. A set loads
// all six fields only if every one checks out (day against the new year's
// month length, year within year_min..year_max); otherwise the time is kept
// and set_error is raised for that result. Every request returns exactly one
// result, the time after it. A request is taken every cycle as long as the
// result side takes results: the time registers update in a single pass of
// carry and compare logic and double as the result register, so in_stall
// follows out_stall only while a result is held. The user must write
// year_min and year_max through the cfg port only while idle; not enforced.
module calendar_clock_counter (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [calclk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [calclk_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [calclk_pkg::MONTH_W-1:0]    new_month,
  input  logic [calclk_pkg::DAY_W-1:0]      new_day,
  input  logic [calclk_pkg::YEAR_W-1:0]     new_year,
  input  logic [calclk_pkg::HOUR_W-1:0]     new_hour,
  input  logic [calclk_pkg::MIN_W-1:0]      new_minute,
  input  logic [calclk_pkg::SEC_W-1:0]      new_second,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [calclk_pkg::SEC_W-1:0]      cur_second,
  output logic [calclk_pkg::MIN_W-1:0]      cur_minute,
  output logic [calclk_pkg::HOUR_W-1:0]     cur_hour,
  output logic [calclk_pkg::DAY_W-1:0]      cur_day,
  output logic [calclk_pkg::MONTH_W-1:0]    cur_month,
  output logic [calclk_pkg::YEAR_W-1:0]     cur_year,
  output logic [calclk_pkg::H12_W-1:0]      hour_twelve,
  output logic                             is_pm,
  output logic                             set_error
);
  import calclk_pkg::*;

  logic [YEAR_W-1:0]  year_min;
  logic [YEAR_W-1:0]  year_max;

  logic [SEC_W-1:0]   second_next;
  logic [MIN_W-1:0]   minute_next;
  logic [HOUR_W-1:0]  hour_next;
  logic [DAY_W-1:0]   day_next;
  logic [MONTH_W-1:0] month_next;
  logic [YEAR_W-1:0]  year_next;
  logic               error_next;
  logic [H12_W-1:0]   twelve_next;

  logic               accept;
  logic               leap_cur;
  logic               leap_new;
  logic               set_ok;
  logic               sec_wrap;
  logic               min_wrap;
  logic               hour_wrap;
  logic               day_wrap;
  logic               month_wrap;

  // a result that is held blocks the next request
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      year_min <= YEAR_MIN_RESET;
      year_max <= YEAR_MAX_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_YEAR_MIN: year_min <= cfg_data;
        REG_YEAR_MAX: year_max <= cfg_data;
        default:      ;
      endcase
    end
  end

  // tick carry chain
  assign leap_cur   = is_leap(cur_year);
  assign sec_wrap   = (cur_second >= SEC_LAST);
  assign min_wrap   = sec_wrap && (cur_minute >= MIN_LAST);
  assign hour_wrap  = min_wrap && (cur_hour >= HOUR_LAST);
  assign day_wrap   = hour_wrap && (cur_day >= days_in(cur_month, leap_cur));
  assign month_wrap = day_wrap && (cur_month >= MONTH_LAST);

  // set checks, february judged by the new year
  assign leap_new = is_leap(new_year);
  assign set_ok   = (new_month >= MONTH_RESET) && (new_month <= MONTH_LAST)
                 && (new_year >= year_min) && (new_year <= year_max)
                 && (new_day >= DAY_RESET) && (new_day <= days_in(new_month, leap_new))
                 && (new_hour <= HOUR_LAST) && (new_minute <= MIN_LAST)
                 && (new_second <= SEC_LAST);

  // next time and date
  always_comb begin
    second_next = cur_second;
    minute_next = cur_minute;
    hour_next   = cur_hour;
    day_next    = cur_day;
    month_next  = cur_month;
    year_next   = cur_year;
    error_next  = 1'b0;
    unique case (req_t'(req_type))
      REQ_TICK: begin
        second_next = sec_wrap  ? '0 : cur_second + SEC_W'(1);
        if (sec_wrap)  minute_next = min_wrap  ? '0 : cur_minute + MIN_W'(1);
        if (min_wrap)  hour_next   = hour_wrap ? '0 : cur_hour + HOUR_W'(1);
        if (hour_wrap) day_next    = day_wrap  ? DAY_RESET : cur_day + DAY_W'(1);
        if (day_wrap)  month_next  = month_wrap ? MONTH_RESET : cur_month + MONTH_W'(1);
        if (month_wrap) year_next  = cur_year + YEAR_W'(1);
      end
      REQ_SET: begin
        if (set_ok) begin
          second_next = new_second;
          minute_next = new_minute;
          hour_next   = new_hour;
          day_next    = new_day;
          month_next  = new_month;
          year_next   = new_year;
        end else begin
          error_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // 12-hour view of the next hour
  always_comb begin
    if (hour_next == '0 || hour_next == HOUR_NOON) begin
      twelve_next = H12_TWELVE;
    end else if (hour_next > HOUR_NOON) begin
      twelve_next = H12_W'(hour_next - HOUR_NOON);
    end else begin
      twelve_next = H12_W'(hour_next);
    end
  end

  // time registers double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      cur_second  <= '0;
      cur_minute  <= '0;
      cur_hour    <= '0;
      cur_day     <= DAY_RESET;
      cur_month   <= MONTH_RESET;
      cur_year    <= YEAR_RESET;
      hour_twelve <= H12_TWELVE;
      is_pm       <= 1'b0;
      set_error   <= 1'b0;
    end else if (accept) begin
      out_valid   <= 1'b1;
      cur_second  <= second_next;
      cur_minute  <= minute_next;
      cur_hour    <= hour_next;
      cur_day     <= day_next;
      cur_month   <= month_next;
      cur_year    <= year_next;
      hour_twelve <= twelve_next;
      is_pm       <= (hour_next >= HOUR_NOON);
      set_error   <= error_next;
    end else if (!out_stall) begin
      out_valid   <= 1'b0;
    end
  end

  // time fields stay in range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_second <= SEC_LAST) && (cur_minute <= MIN_LAST)
                  && (cur_hour <= HOUR_LAST) && (cur_day >= DAY_RESET)
                  && (cur_month >= MONTH_RESET) && (cur_month <= MONTH_LAST))
    else $error("time field out of range");

  // 12-hour view agrees with the 24-hour hour
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_pm == (cur_hour >= HOUR_NOON))
                  && (hour_twelve >= 4'd1) && (hour_twelve <= H12_TWELVE))
    else $error("12-hour view inconsistent");

  // a tick never reports a set error
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_TICK) |=> !set_error)
    else $error("set error on tick");

  // a rejected set keeps the time unchanged
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_SET) && !set_ok |=>
      $stable(cur_second) && $stable(cur_minute) && $stable(cur_hour)
      && $stable(cur_day) && $stable(cur_month) && $stable(cur_year))
    else $error("rejected set changed the time");

  // every accepted request yields a result
  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("request lost");

endmodule

>>> test/calendar_check.sv
// calendar clock checker: follows the request and result channels, keeps its own
// copy of the clock and the year limits, and compares every result with its prediction
// depends on calclk_pkg
module calendar_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [calclk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [calclk_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              req_type,
  input  logic [calclk_pkg::MONTH_W-1:0]    new_month,
  input  logic [calclk_pkg::DAY_W-1:0]      new_day,
  input  logic [calclk_pkg::YEAR_W-1:0]     new_year,
  input  logic [calclk_pkg::HOUR_W-1:0]     new_hour,
  input  logic [calclk_pkg::MIN_W-1:0]      new_minute,
  input  logic [calclk_pkg::SEC_W-1:0]      new_second,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [calclk_pkg::SEC_W-1:0]      cur_second,
  input  logic [calclk_pkg::MIN_W-1:0]      cur_minute,
  input  logic [calclk_pkg::HOUR_W-1:0]     cur_hour,
  input  logic [calclk_pkg::DAY_W-1:0]      cur_day,
  input  logic [calclk_pkg::MONTH_W-1:0]    cur_month,
  input  logic [calclk_pkg::YEAR_W-1:0]     cur_year,
  input  logic [calclk_pkg::H12_W-1:0]      hour_twelve,
  input  logic                              is_pm,
  input  logic                              set_error,
  output int                                fail_count,
  output int                                pending,
  output int                                result_count,
  output int                                reject_count,
  output int                                wrap_count,
  output int                                leap_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import calclk_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } stamp_t;

  typedef struct packed {
    stamp_t             at;
    logic [H12_W-1:0]   hour12;
    logic               pm;
    logic               rejected;
  } clock_view_t;

  // gregorian month lengths, codes 0 and 13..15 read as 31
  localparam logic [DAY_W-1:0] DAYS_PER_MONTH [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };
  localparam logic [YEAR_W-1:0] START_YEAR   = 12'd1900;
  localparam logic [YEAR_W-1:0] START_YEAR_HI = 12'd2020;

  stamp_t              now_time;
  stamp_t              req_time;
  logic [YEAR_W-1:0]   year_lo;
  logic [YEAR_W-1:0]   year_hi;
  logic                rejected;
  clock_view_t         expected_views [$];
  clock_view_t         want_view;

  function automatic bit leap_year(input logic [YEAR_W-1:0] y);
    int v;
    v = int'(y);
    return (v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0));
  endfunction

  function automatic int month_days(input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
    int n;
    n = int'(DAYS_PER_MONTH[m]);
    if (m == 4'd2 && leap_year(y)) n = 29;
    return n;
  endfunction

  // one second forward with carries up to the year, which wraps at 12 bits
  function automatic stamp_t tick_forward(input stamp_t t);
    stamp_t n;
    n = t;
    if (n.second < 59) begin
      n.second = n.second + 1'b1;
    end else begin
      n.second = '0;
      if (n.minute < 59) begin
        n.minute = n.minute + 1'b1;
      end else begin
        n.minute = '0;
        if (n.hour < 23) begin
          n.hour = n.hour + 1'b1;
        end else begin
          n.hour = '0;
          if (n.day >= month_days(n.month, n.year)) begin
            n.day = 5'd1;
            if (n.month >= 12) begin
              n.month = 4'd1;
              n.year  = n.year + 1'b1;
            end else begin
              n.month = n.month + 1'b1;
            end
          end else begin
            n.day = n.day + 1'b1;
          end
        end
      end
    end
    return n;
  endfunction

  // every field of a set request in range, leap day judged on the new year
  function automatic bit set_ok(input stamp_t s, input logic [YEAR_W-1:0] lo,
                                input logic [YEAR_W-1:0] hi);
    return (s.month >= 1) && (s.month <= 12) && (s.year >= lo) && (s.year <= hi) &&
           (s.day >= 1) && (s.day <= month_days(s.month, s.year)) &&
           (s.hour <= 23) && (s.minute <= 59) && (s.second <= 59);
  endfunction

  function automatic clock_view_t make_view(input stamp_t t, input logic bad);
    clock_view_t v;
    v.at       = t;
    v.hour12   = (t.hour == 0 || t.hour == 12) ? H12_W'(12) : H12_W'(t.hour % 12);
    v.pm       = (t.hour >= 12);
    v.rejected = bad;
    return v;
  endfunction

  task automatic check_field(input string name, input logic [YEAR_W-1:0] want,
                             input logic [YEAR_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      now_time = '{year: START_YEAR, month: 4'd1, day: 5'd1, hour: '0, minute: '0, second: '0};
      year_lo  = START_YEAR;
      year_hi  = START_YEAR_HI;
      expected_views.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_YEAR_MIN: year_lo = cfg_data;
          REG_YEAR_MAX: year_hi = cfg_data;
          default: ;
        endcase
      end

      // result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want_view = expected_views.pop_front();
          check_field("cur_second", YEAR_W'(want_view.at.second), YEAR_W'(cur_second));
          check_field("cur_minute", YEAR_W'(want_view.at.minute), YEAR_W'(cur_minute));
          check_field("cur_hour", YEAR_W'(want_view.at.hour), YEAR_W'(cur_hour));
          check_field("cur_day", YEAR_W'(want_view.at.day), YEAR_W'(cur_day));
          check_field("cur_month", YEAR_W'(want_view.at.month), YEAR_W'(cur_month));
          check_field("cur_year", want_view.at.year, cur_year);
          check_field("hour_twelve", YEAR_W'(want_view.hour12), YEAR_W'(hour_twelve));
          check_field("is_pm", YEAR_W'(want_view.pm), YEAR_W'(is_pm));
          check_field("set_error", YEAR_W'(want_view.rejected), YEAR_W'(set_error));
          result_count++;
        end
      end

      // request side: advance or load the clock
      if (in_valid && !in_stall) begin
        rejected = 1'b0;
        if (req_type == REQ_SET) begin
          req_time = '{year: new_year, month: new_month, day: new_day, hour: new_hour,
                       minute: new_minute, second: new_second};
          if (set_ok(req_time, year_lo, year_hi)) begin
            now_time = req_time;
          end else begin
            rejected = 1'b1;
            reject_count++;
          end
        end else begin
          if (now_time.year == 12'hfff && tick_forward(now_time).year == '0) wrap_count++;
          now_time = tick_forward(now_time);
          if (now_time.month == 4'd2 && now_time.day == 5'd29 && now_time.hour == '0 &&
              now_time.minute == '0 && now_time.second == '0) leap_count++;
        end
        expected_views.push_back(make_view(now_time, rejected));
      end
    end
    pending = expected_views.size();
  end

endmodule

>>> test/tb_top.sv
// calendar clock testbench top: clock, reset, request and register stimulus,
// random stalls on the result side and the final verdict
// depends on calclk_pkg, calendar_clock_counter and calendar_check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import calclk_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASES       = 12;
  localparam int PHASE_REQS   = 140;
  localparam int QUIET_FROM   = 10;
  localparam int TAIL_CYCLES  = 4;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  req_type;
  logic [MONTH_W-1:0]    new_month;
  logic [DAY_W-1:0]      new_day;
  logic [YEAR_W-1:0]     new_year;
  logic [HOUR_W-1:0]     new_hour;
  logic [MIN_W-1:0]      new_minute;
  logic [SEC_W-1:0]      new_second;
  logic                  out_valid;
  logic                  out_stall;
  logic [SEC_W-1:0]      cur_second;
  logic [MIN_W-1:0]      cur_minute;
  logic [HOUR_W-1:0]     cur_hour;
  logic [DAY_W-1:0]      cur_day;
  logic [MONTH_W-1:0]    cur_month;
  logic [YEAR_W-1:0]     cur_year;
  logic [H12_W-1:0]      hour_twelve;
  logic                  is_pm;
  logic                  set_error;

  int fail_count;
  int pending;
  int result_count;
  int reject_count;
  int wrap_count;
  int leap_count;

  int                cycles;
  int                sent;
  int                gap_pct;
  int                stall_pct;
  bit                hold_results;
  bit                paused;
  logic [YEAR_W-1:0] lim_lo;
  logic [YEAR_W-1:0] lim_hi;

  calendar_clock_counter u_top (.*);
  calendar_check u_check (.*);

  always #5ns clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_results = 1'b0;
        out_stall = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(15, 1) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // offer one request and hold it until taken, then maybe leave a gap
  task automatic send_req(input req_t kind, input logic [MONTH_W-1:0] mo,
                          input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y,
                          input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] mi,
                          input logic [SEC_W-1:0] s);
    @(negedge clk);
    in_valid   = 1'b1;
    req_type   = kind;
    new_month  = mo;
    new_day    = d;
    new_year   = y;
    new_hour   = h;
    new_minute = mi;
    new_second = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(15, 1) - 1) @(negedge clk);
    end
  endtask

  task automatic send_set(input int y, input int mo, input int d, input int h,
                          input int mi, input int s);
    send_req(REQ_SET, MONTH_W'(mo), DAY_W'(d), YEAR_W'(y), HOUR_W'(h), MIN_W'(mi),
             SEC_W'(s));
  endtask

  // ticks carry random payload, which the block must ignore
  task automatic send_ticks(input int n);
    repeat (n) begin
      send_req(REQ_TICK, MONTH_W'($urandom), DAY_W'($urandom), YEAR_W'($urandom),
               HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
    end
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limits(input int lo, input int hi);
    settle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = REG_YEAR_MIN;
    cfg_data  = CFG_DATA_W'(lo);
    @(negedge clk);
    cfg_index = REG_YEAR_MAX;
    cfg_data  = CFG_DATA_W'(hi);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    lim_lo    = YEAR_W'(lo);
    lim_hi    = YEAR_W'(hi);
  endtask

  // in-limit year (any if crossed), often rounded down to a leap-rule boundary
  function automatic logic [YEAR_W-1:0] pick_year();
    int y;
    int r;
    if (lim_lo <= lim_hi) begin
      y = $urandom_range(lim_hi, lim_lo);
      case ($urandom_range(3, 0))
        1:       r = y - y % 4;
        2:       r = y - y % 100;
        3:       r = y - y % 400;
        default: r = y;
      endcase
      if (r >= lim_lo) y = r;
    end else begin
      y = $urandom_range(4095, 0);
    end
    return YEAR_W'(y);
  endfunction

  // one random sequence: mostly valid sets followed by ticks
  task automatic run_burst();
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   d;
    logic [YEAR_W-1:0]  y;
    logic [HOUR_W-1:0]  h;
    logic [MIN_W-1:0]   mi;
    logic [SEC_W-1:0]   s;
    y  = pick_year();
    mo = MONTH_W'($urandom_range(12, 1));
    d  = DAY_W'($urandom_range(28, 1));
    h  = HOUR_W'($urandom_range(23, 0));
    mi = MIN_W'($urandom_range(59, 0));
    s  = SEC_W'($urandom_range(59, 0));
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: begin
        // land just short of a day, month or year carry
        if ($urandom_range(3, 0) == 0) begin
          mo = 4'd12;
          d  = 5'd31;
        end else begin
          d = DAY_W'($urandom_range(31, 28));
        end
        if ($urandom_range(3, 0) != 0) h = 5'd23;
        if ($urandom_range(3, 0) != 0) mi = 6'd59;
        s = SEC_W'($urandom_range(59, 50));
        send_req(REQ_SET, mo, d, y, h, mi, s);
        send_ticks($urandom_range(12, 1));
      end
      5, 6: begin
        send_req(REQ_SET, mo, d, y, h, mi, s);
        send_ticks($urandom_range(5, 0));
      end
      7: begin
        send_req(REQ_SET, MONTH_W'($urandom), DAY_W'($urandom), YEAR_W'($urandom),
                 HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
      end
      8: begin
        send_ticks($urandom_range(40, 5));
      end
      default: begin
        // valid set with one field broken
        case ($urandom_range(5, 0))
          0: mo = ($urandom_range(1, 0) != 0) ? 4'd0 : MONTH_W'($urandom_range(15, 13));
          1: d  = 5'd0;
          2: h  = HOUR_W'($urandom_range(31, 24));
          3: mi = MIN_W'($urandom_range(63, 60));
          4: s  = SEC_W'($urandom_range(63, 60));
          default: begin
            if (lim_lo > 0) y = lim_lo - 1'b1;
            else if (lim_hi < 12'hfff) y = lim_hi + 1'b1;
            else mo = 4'd0;
          end
        endcase
        send_req(REQ_SET, mo, d, y, h, mi, s);
        send_ticks($urandom_range(2, 0));
      end
    endcase
  endtask

  initial begin
    int lo;
    int hi;
    int target;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_YEAR_MIN;
    cfg_data     = '0;
    in_valid     = 1'b0;
    req_type     = REQ_TICK;
    new_month    = '0;
    new_day      = '0;
    new_year     = '0;
    new_hour     = '0;
    new_minute   = '0;
    new_second   = '0;
    gap_pct      = 20;
    stall_pct    = 20;
    hold_results = 1'b0;
    paused       = 1'b0;
    lim_lo       = 12'd1900;
    lim_hi       = 12'd2020;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: carries, leap rules and rejected fields under the reset limits
    send_ticks(1);
    send_set(1900, 2, 28, 23, 59, 59);
    send_ticks(1);
    send_set(1900, 2, 29, 12, 0, 0);
    send_set(2000, 2, 29, 23, 59, 59);
    send_ticks(1);
    send_set(2020, 12, 31, 23, 59, 59);
    send_ticks(1);
    send_set(2010, 0, 10, 1, 1, 1);
    send_set(2010, 15, 10, 1, 1, 1);
    send_set(2010, 4, 31, 1, 1, 1);
    send_set(2010, 6, 0, 1, 1, 1);
    send_set(2010, 6, 10, 24, 1, 1);
    send_set(2010, 6, 10, 1, 63, 1);
    send_set(2010, 6, 10, 1, 1, 60);
    send_set(1899, 6, 10, 1, 1, 1);
    send_set(2021, 6, 10, 1, 1, 1);
    send_set(4095, 15, 31, 31, 63, 63);
    send_set(2010, 6, 15, 12, 0, 0);

    // full year range: wrap to year 0, which is a leap year
    set_limits(0, 4095);
    send_set(4095, 12, 31, 23, 59, 59);
    send_ticks(1);
    send_set(0, 2, 29, 0, 0, 0);

    // crossed limits reject every set
    set_limits(2000, 1999);
    send_set(2000, 1, 1, 0, 0, 0);

    // random phases, each under its own limits
    for (int p = 0; p < PHASES; p++) begin
      case ((p + 1) % 6)
        0: set_limits(0, 4095);
        1: begin
          lo = $urandom_range(4095, 0);
          hi = $urandom_range(4095, 0);
          if (lo > hi) set_limits(hi, lo);
          else set_limits(lo, hi);
        end
        2: set_limits(1900, 2020);
        3: begin
          lo = $urandom_range(4095, 1);
          hi = $urandom_range(lo - 1, 0);
          set_limits(lo, hi);
        end
        4: set_limits(4095, 4095);
        default: set_limits(0, 0);
      endcase
      if (p >= QUIET_FROM) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 20 * $urandom_range(2, 0);
        stall_pct = 20 * $urandom_range(2, 0);
      end
      // long result hold while requests keep coming
      if (p == 1) hold_results = 1'b1;
      target = sent + PHASE_REQS;
      while (sent < target) begin
        run_burst();
        // sender pause until all results are back
        if (p == 3 && !paused && sent > target - PHASE_REQS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d requests and %0d results, %0d sets rejected",
             sent, result_count, reject_count);
    $display("ticks wrapped the year %0d times and entered a leap day %0d times",
             wrap_count, leap_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
